[hdl/vau_pkg.sv]
// Shared constants, types and saturation helpers for the vector arithmetic unit.
package vau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int SAT_BITS  = (WORD_BITS < 32) ? WORD_BITS : 32;
  localparam int MW        = 66;
  localparam int DVW       = 32 + FRAC_BITS;
  localparam int NS        = 32;
  localparam int ND        = DVW;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  localparam logic [3:0] CMD_ADD    = 4'd0;
  localparam logic [3:0] CMD_SUB    = 4'd1;
  localparam logic [3:0] CMD_SCALE  = 4'd2;
  localparam logic [3:0] CMD_MUL    = 4'd3;
  localparam logic [3:0] CMD_DIV    = 4'd4;
  localparam logic [3:0] CMD_DOT    = 4'd5;
  localparam logic [3:0] CMD_CROSS  = 4'd6;
  localparam logic [3:0] CMD_SQUARE = 4'd7;
  localparam logic [3:0] CMD_MAG    = 4'd8;
  localparam logic [3:0] CMD_NORM   = 4'd9;
  localparam logic [3:0] CMD_DIST   = 4'd10;

  localparam logic [MW-1:0] MAX_POS = (MW'(1) << (SAT_BITS - 1)) - MW'(1);
  localparam logic [MW-1:0] MAX_NEG = MW'(1) << (SAT_BITS - 1);

  typedef logic [31:0] mag_t;
  typedef logic [31:0] word_t;

  typedef struct packed {
    logic  flag;
    word_t val;
  } satres_t;

  // Decoded request as it leaves the front end
  typedef struct packed {
    logic [3:0]       cmd;
    logic [2:0]       a_neg;
    mag_t [2:0]       a_mag;
    logic             s_neg;
    mag_t             s_mag;
    word_t [2:0]      r_pre;
    logic             sat;
    logic [5:0]       m_neg;
    mag_t [5:0]       m_a;
    mag_t [5:0]       m_b;
  } fe_t;

  // Context carried down the back-end pipeline
  typedef struct packed {
    logic [3:0]  cmd;
    logic [2:0]  a_neg;
    mag_t [2:0]  a_mag;
    logic        s_neg;
    mag_t        s_mag;
    word_t [2:0] r;
    word_t       scal;
    logic        sat;
    logic        err;
  } ctx_t;

  function automatic mag_t to_mag(input word_t v);
    return v[31] ? 32'(~v + 32'd1) : v;
  endfunction

  function automatic logic [MW-1:0] abs_s(input logic [MW-1:0] v);
    return v[MW-1] ? (~v + MW'(1)) : v;
  endfunction

  // Clip a sign-magnitude value to the result range
  function automatic satres_t sat_sm(input logic neg, input logic [MW-1:0] mag);
    satres_t r;
    logic [MW-1:0] m;
    r.flag = 1'b0;
    m = mag;
    if (!neg) begin
      if (m > MAX_POS) begin
        m = MAX_POS;
        r.flag = 1'b1;
      end
      r.val = m[31:0];
    end else begin
      if (m > MAX_NEG) begin
        m = MAX_NEG;
        r.flag = 1'b1;
      end
      r.val = 32'(~m[31:0] + 32'd1);
    end
    return r;
  endfunction

endpackage

[hdl/vau_in_if.sv]
// Request channel: operation code, two vectors and a scalar.
interface vau_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scalar_in;

  modport source (output valid, command, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                  input ready);
  modport sink (input valid, command, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                output ready);
endinterface

[hdl/vau_out_if.sv]
// Result channel: vector, scalar and status flags.
interface vau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [31:0] scalar_out;
  logic               error_flag;
  logic               saturated;

  modport source (output valid, r_x, r_y, r_z, scalar_out, error_flag, saturated,
                  input ready);
  modport sink (input valid, r_x, r_y, r_z, scalar_out, error_flag, saturated,
                output ready);
endinterface

[hdl/vau_front.sv]
// Front end: accepts requests, converts operands and picks multiplier inputs.
module vau_front (
  input  logic          clk,
  input  logic          rst,
  vau_in_if.sink        operands,
  output vau_pkg::fe_t  push_data,
  output logic          push,
  input  logic          full
);
  import vau_pkg::*;

  fe_t   f_d;
  fe_t   f_next;
  logic  f_valid;
  word_t av [3];
  word_t bv [3];

  assign av[0] = operands.a_x;
  assign av[1] = operands.a_y;
  assign av[2] = operands.a_z;
  assign bv[0] = operands.b_x;
  assign bv[1] = operands.b_y;
  assign bv[2] = operands.b_z;

  // Refuse requests while reset is held
  assign operands.ready = !rst && (!f_valid || !full);
  assign push           = f_valid && !full;
  assign push_data      = f_d;

  // Decode the request
  always_comb begin
    logic signed [32:0] ds;
    logic [32:0]        dm;
    satres_t            sr;
    mag_t               dmag [3];
    mag_t               b_mag [3];
    logic [2:0]         b_neg;
    logic [3:0]         cmd;
    cmd = operands.command;
    f_next = '0;
    f_next.cmd = cmd;
    f_next.s_neg = operands.scalar_in[31];
    f_next.s_mag = to_mag(operands.scalar_in);
    for (int i = 0; i < 3; i++) begin
      f_next.a_neg[i] = av[i][31];
      f_next.a_mag[i] = to_mag(av[i]);
      b_neg[i] = bv[i][31];
      b_mag[i] = to_mag(bv[i]);
      if (cmd == CMD_ADD) begin
        ds = {av[i][31], av[i]} + {bv[i][31], bv[i]};
      end else begin
        ds = {av[i][31], av[i]} - {bv[i][31], bv[i]};
      end
      dm = ds[32] ? 33'(-ds) : 33'(ds);
      sr = sat_sm(ds[32], MW'(dm));
      f_next.r_pre[i] = sr.val;
      dmag[i] = to_mag(sr.val);
      if (cmd == CMD_ADD || cmd == CMD_SUB || cmd == CMD_DIST) begin
        f_next.sat = f_next.sat | sr.flag;
      end
    end
    // Route multiplier operands
    case (cmd)
      CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          f_next.m_a[i] = f_next.a_mag[i];
          f_next.m_b[i] = f_next.s_mag;
          f_next.m_neg[i] = f_next.a_neg[i] ^ f_next.s_neg;
        end
      end
      CMD_MUL, CMD_DOT: begin
        for (int i = 0; i < 3; i++) begin
          f_next.m_a[i] = f_next.a_mag[i];
          f_next.m_b[i] = b_mag[i];
          f_next.m_neg[i] = f_next.a_neg[i] ^ b_neg[i];
        end
      end
      CMD_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          f_next.m_a[i]   = f_next.a_mag[(i + 1) % 3];
          f_next.m_b[i]   = b_mag[(i + 2) % 3];
          f_next.m_neg[i] = f_next.a_neg[(i + 1) % 3] ^ b_neg[(i + 2) % 3];
          f_next.m_a[i + 3]   = f_next.a_mag[(i + 2) % 3];
          f_next.m_b[i + 3]   = b_mag[(i + 1) % 3];
          f_next.m_neg[i + 3] = f_next.a_neg[(i + 2) % 3] ^ b_neg[(i + 1) % 3];
        end
      end
      CMD_SQUARE, CMD_MAG, CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          f_next.m_a[i] = f_next.a_mag[i];
          f_next.m_b[i] = f_next.a_mag[i];
        end
      end
      CMD_DIST: begin
        for (int i = 0; i < 3; i++) begin
          f_next.m_a[i] = dmag[i];
          f_next.m_b[i] = dmag[i];
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the decoded request until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (operands.ready) begin
      f_valid <= operands.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (operands.valid && operands.ready) begin
      f_d <= f_next;
    end
  end

endmodule

[hdl/vau_queue.sv]
// Short request queue between the front end and the back end.
module vau_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vau_pkg::fe_t  push_data,
  output logic          full,
  input  logic          pop,
  output vau_pkg::fe_t  head,
  output logic          head_valid
);
  import vau_pkg::*;

  fe_t            mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full       = (count == (QAW + 1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");

endmodule

[hdl/vau_back.sv]
// Back end: multiply, combine, square root and divide pipeline with output register.
module vau_back (
  input  logic          clk,
  input  logic          rst,
  input  vau_pkg::fe_t  head,
  input  logic          head_valid,
  output logic          pop,
  vau_out_if.source     results
);
  import vau_pkg::*;

  typedef struct packed {
    ctx_t             c;
    logic [5:0]       pneg;
    logic [5:0][63:0] p;
  } m_t;

  typedef struct packed {
    ctx_t               c;
    logic [5:0][MW-1:0] sp;
    logic [MW-1:0]      sq;
  } s1_t;

  typedef struct packed {
    ctx_t               c;
    logic [2:0][MW-1:0] v;
    logic [MW-1:0]      dsum;
    logic [MW-1:0]      sq;
  } s2_t;

  typedef struct packed {
    ctx_t        c;
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] n;
  } sq_t;

  typedef struct packed {
    logic [31:0]    rem;
    logic [DVW-1:0] dvd;
    logic [DVW-1:0] q;
  } lane_t;

  typedef struct packed {
    ctx_t        c;
    mag_t        dsr;
    logic [2:0]  qneg;
    lane_t [2:0] ln;
  } dv_t;

  // One digit of the integer square root
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t         r;
    logic [35:0] rem2;
    logic [35:0] trial;
    r = s;
    rem2  = {s.rem[33:0], s.n[63:62]};
    trial = {2'b00, s.root, 2'b01};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[30:0], 1'b0};
    end
    r.n = {s.n[61:0], 2'b00};
    return r;
  endfunction

  // One quotient bit of restoring division
  function automatic lane_t div_step(input lane_t l, input mag_t d);
    lane_t       r;
    logic [32:0] rem2;
    logic [32:0] diff;
    rem2 = {l.rem, l.dvd[DVW-1]};
    diff = rem2 - {1'b0, d};
    if (rem2 >= {1'b0, d}) begin
      r.rem = diff[31:0];
      r.q   = {l.q[DVW-2:0], 1'b1};
    end else begin
      r.rem = rem2[31:0];
      r.q   = {l.q[DVW-2:0], 1'b0};
    end
    r.dvd = {l.dvd[DVW-2:0], 1'b0};
    return r;
  endfunction

  logic        adv;
  logic        out_valid;
  m_t          ms;
  s1_t         s1;
  s2_t         s2;
  logic        mv, s1v, s2v;
  sq_t         sqs [NS+1];
  logic [NS:0] sqv;
  dv_t         dvs [ND+1];
  logic [ND:0] dvv;
  m_t          ms_next;
  s1_t         s1_next;
  s2_t         s2_next;
  sq_t         t_next;
  dv_t         e_next;
  word_t [2:0] o_r, o_r_next;
  word_t       o_scal;
  logic        o_err;
  logic        o_sat, o_sat_next;
  logic [3:0]  o_cmd;

  // The whole pipeline moves together while the output slot is free
  assign adv = !out_valid || results.ready;
  assign pop = adv && head_valid;

  // Multiply stage
  always_comb begin
    ms_next = '0;
    ms_next.c.cmd   = head.cmd;
    ms_next.c.a_neg = head.a_neg;
    ms_next.c.a_mag = head.a_mag;
    ms_next.c.s_neg = head.s_neg;
    ms_next.c.s_mag = head.s_mag;
    ms_next.c.r     = head.r_pre;
    ms_next.c.sat   = head.sat;
    ms_next.pneg    = head.m_neg;
    for (int i = 0; i < 6; i++) begin
      ms_next.p[i] = 64'(head.m_a[i]) * 64'(head.m_b[i]);
    end
  end

  // Signed products and sum of squares
  always_comb begin
    s1_next.c = ms.c;
    for (int i = 0; i < 6; i++) begin
      s1_next.sp[i] = ms.pneg[i] ? (~MW'(ms.p[i]) + MW'(1)) : MW'(ms.p[i]);
    end
    s1_next.sq = MW'(ms.p[0]) + MW'(ms.p[1]) + MW'(ms.p[2]);
  end

  // Cross differences and dot sum
  always_comb begin
    s2_next.c  = s1.c;
    s2_next.sq = s1.sq;
    for (int i = 0; i < 3; i++) begin
      s2_next.v[i] = (s1.c.cmd == CMD_CROSS) ? (s1.sp[i] - s1.sp[i + 3]) : s1.sp[i];
    end
    s2_next.dsum = s1.sp[0] + s1.sp[1] + s1.sp[2];
  end

  // Truncate and clip the product results, seed the root
  always_comb begin
    satres_t sr;
    t_next.c = s2.c;
    t_next.rem  = '0;
    t_next.root = '0;
    t_next.n    = s2.sq[63:0];
    sr = '0;
    case (s2.c.cmd)
      CMD_ADD, CMD_SUB: begin
      end
      CMD_SCALE, CMD_MUL, CMD_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          sr = sat_sm(s2.v[i][MW-1], abs_s(s2.v[i]) >> FRAC_BITS);
          t_next.c.r[i] = sr.val;
          t_next.c.sat  = t_next.c.sat | sr.flag;
        end
      end
      CMD_DOT: begin
        t_next.c.r = '0;
        sr = sat_sm(s2.dsum[MW-1], abs_s(s2.dsum) >> FRAC_BITS);
        t_next.c.scal = sr.val;
        t_next.c.sat  = sr.flag;
      end
      CMD_SQUARE: begin
        t_next.c.r = '0;
        sr = sat_sm(1'b0, s2.sq >> FRAC_BITS);
        t_next.c.scal = sr.val;
        t_next.c.sat  = sr.flag;
      end
      default: begin
        t_next.c.r = '0;
      end
    endcase
  end

  // Pick divisor and set up the three divider lanes
  always_comb begin
    satres_t sr;
    sq_t     sf;
    sf = sqs[NS];
    e_next.c = sf.c;
    e_next.dsr = (sf.c.cmd == CMD_DIV) ? sf.c.s_mag : sf.root;
    case (sf.c.cmd)
      CMD_MAG, CMD_DIST: begin
        sr = sat_sm(1'b0, MW'(sf.root));
        e_next.c.scal = sr.val;
        e_next.c.sat  = sf.c.sat | sr.flag;
      end
      CMD_NORM: begin
        sr = '0;
        e_next.c.err = (sf.root == '0);
      end
      CMD_DIV: begin
        sr = '0;
        e_next.c.err = (sf.c.s_mag == '0);
      end
      default: begin
        sr = '0;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      e_next.ln[i].rem = '0;
      e_next.ln[i].q   = '0;
      e_next.ln[i].dvd = {sf.c.a_mag[i], {FRAC_BITS{1'b0}}};
      e_next.qneg[i]   = sf.c.a_neg[i] ^ ((sf.c.cmd == CMD_DIV) && sf.c.s_neg);
    end
  end

  // Final clipping of quotients
  always_comb begin
    satres_t       sr;
    dv_t           df;
    logic [MW-1:0] mag;
    df = dvs[ND];
    o_r_next   = df.c.r;
    o_sat_next = df.c.sat;
    for (int i = 0; i < 3; i++) begin
      mag = MW'(df.ln[i].q);
      if (df.c.cmd == CMD_DIV && df.c.err) begin
        mag = (df.c.a_mag[i] != '0) ? '1 : '0;
      end
      sr = sat_sm(df.qneg[i], mag);
      if (df.c.cmd == CMD_DIV || df.c.cmd == CMD_NORM) begin
        if (df.c.cmd == CMD_NORM && df.c.err) begin
          o_r_next[i] = '0;
        end else begin
          o_r_next[i] = sr.val;
          o_sat_next  = o_sat_next | sr.flag;
        end
      end
    end
  end

  // Valid bits of the front stages and the output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      mv        <= 1'b0;
      s1v       <= 1'b0;
      s2v       <= 1'b0;
      sqv[0]    <= 1'b0;
      dvv[0]    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      mv        <= head_valid;
      s1v       <= mv;
      s2v       <= s1v;
      sqv[0]    <= s2v;
      dvv[0]    <= sqv[NS];
      out_valid <= dvv[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ms      <= ms_next;
      s1      <= s1_next;
      s2      <= s2_next;
      sqs[0]  <= t_next;
      dvs[0]  <= e_next;
      o_r     <= o_r_next;
      o_scal  <= dvs[ND].c.scal;
      o_err   <= dvs[ND].c.err;
      o_sat   <= o_sat_next;
      o_cmd   <= dvs[ND].c.cmd;
    end
  end

  // Square root stages
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[k + 1] <= 1'b0;
      end else if (adv) begin
        sqv[k + 1] <= sqv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sqs[k + 1] <= sqrt_step(sqs[k]);
      end
    end
  end

  // Divider stages, three lanes sharing one divisor
  for (genvar k = 0; k < ND; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k + 1] <= 1'b0;
      end else if (adv) begin
        dvv[k + 1] <= dvv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dvs[k + 1].c    <= dvs[k].c;
        dvs[k + 1].dsr  <= dvs[k].dsr;
        dvs[k + 1].qneg <= dvs[k].qneg;
        for (int i = 0; i < 3; i++) begin
          dvs[k + 1].ln[i] <= div_step(dvs[k].ln[i], dvs[k].dsr);
        end
      end
    end
  end

  assign results.valid      = out_valid;
  assign results.r_x        = o_r[0];
  assign results.r_y        = o_r[1];
  assign results.r_z        = o_r[2];
  assign results.scalar_out = o_scal;
  assign results.error_flag = o_err;
  assign results.saturated  = o_sat;

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_err) |-> (o_cmd == CMD_DIV || o_cmd == CMD_NORM))
    else $error("error flag on an operation that cannot fail");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (o_cmd == CMD_DOT || o_cmd == CMD_SQUARE || o_cmd == CMD_MAG ||
                   o_cmd == CMD_DIST)) |-> (o_r == '0))
    else $error("scalar operation left a vector result");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |=> (out_valid && $stable(o_r) && $stable(o_scal)))
    else $error("output slot changed while stalled");

endmodule

[hdl/vector3_arithmetic_unit.sv]
// Top level of the three-component fixed-point vector arithmetic unit.
// Requests arrive on the operands channel (valid/ready): an operation code,
// vectors a and b and a scalar, all signed Q16.16. Each request produces
// exactly one item on the results channel: a vector, a scalar, an error flag
// (divide by zero, normalize of a zero vector) and a saturation flag.
// Throughput is one request per cycle while the receiver holds ready high.
// A request passes the front register, the queue, the multiply and combine
// stages, the 32-stage square-root and the 48-stage divider pipelines;
// every operation takes the same path so results leave in request order.
// When the receiver holds ready low the whole back-end pipeline freezes with
// the result held steady; the four-entry queue and the front register keep
// accepting until they fill, then operands.ready drops.
// Reset (synchronous, active high) empties the front register, the queue and
// every pipeline stage; no request is lost or replayed after reset ends.
module vector3_arithmetic_unit (
  input  logic       clk,
  input  logic       rst,
  vau_in_if.sink     operands,
  vau_out_if.source  results
);
  import vau_pkg::*;

  fe_t  push_data;
  logic push;
  logic full;
  fe_t  head;
  logic head_valid;
  logic pop;

  vau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .operands  (operands),
    .push_data (push_data),
    .push      (push),
    .full      (full)
  );

  vau_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  vau_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .results    (results)
  );

endmodule
